// ----- sv/lwe_msn_pkg.sv -----
// Shared types, codes and defaults for the LWE matrix-times-secret-plus-noise unit.
`default_nettype none

package lwe_msn_pkg;

    localparam int ROWS_N_DEF    = 1024;
    localparam int COLS_NHAT_DEF = 12;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_SECRET = 2'd0;
    localparam logic [1:0] REQ_NOISE  = 2'd1;
    localparam logic [1:0] REQ_ELEM   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  row_index;
        logic [9:0]  col_index;
        logic [31:0] data_value;
        logic        row_done;
    } req_t;

    typedef struct packed {
        logic [31:0] sum_out;
        logic [9:0]  out_row;
        logic [3:0]  out_column;
        logic        last_of_row;
    } rsp_t;

    // Accumulator memory controls
    typedef struct packed {
        logic wr;
        logic rd;
        logic clr;
    } acc_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

`default_nettype wire

// ----- sv/lwe_msn_secret_mem.sv -----
// Secret matrix store: one write port, one registered read port.
`default_nettype none

module lwe_msn_secret_mem #(
    parameter int ROWS_N    = lwe_msn_pkg::ROWS_N_DEF,
    parameter int COLS_NHAT = lwe_msn_pkg::COLS_NHAT_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [$clog2(ROWS_N*COLS_NHAT)-1:0]      wr_addr,
    input  wire logic [31:0]                              wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [$clog2(ROWS_N*COLS_NHAT)-1:0]      rd_addr,
    output logic      [31:0]                              rd_data
);

    localparam int DEPTH = ROWS_N * COLS_NHAT;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/lwe_msn_acc_mem.sv -----
// Accumulator memory with per-entry valid bits; an invalid entry reads as zero.
`default_nettype none

module lwe_msn_acc_mem #(
    parameter int COLS_NHAT = lwe_msn_pkg::COLS_NHAT_DEF,
    localparam int KW       = (COLS_NHAT > 1) ? $clog2(COLS_NHAT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lwe_msn_pkg::acc_ctl_t ctl,
    input  wire logic [KW-1:0]        wr_addr,
    input  wire logic [31:0]          wr_data,
    input  wire logic [KW-1:0]        rd_addr,
    output logic      [31:0]          rd_value
);

    logic [31:0]          mem [COLS_NHAT];
    logic [COLS_NHAT-1:0] vld_reg;
    logic [31:0]          rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Clear goes through the read address; the two never share a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.clr)
            begin
                vld_reg[rd_addr] <= 1'b0;
            end
            if (ctl.rd)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_value = rd_vld_reg ? rd_data_reg : 32'd0;

endmodule

`default_nettype wire

// ----- sv/lwe_msn_mac.sv -----
// Multiply-accumulate pipeline: memory read, multiply, add and write back.
`default_nettype none

module lwe_msn_mac #(
    parameter int COLS_NHAT = lwe_msn_pkg::COLS_NHAT_DEF,
    localparam int KW       = (COLS_NHAT > 1) ? $clog2(COLS_NHAT) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          issue,
    input  wire logic [KW-1:0] issue_k,
    input  wire logic [31:0]   elem,
    input  wire logic [31:0]   secret,
    input  wire logic [31:0]   acc_value,
    output logic               wr_en,
    output logic      [KW-1:0] wr_k,
    output logic      [31:0]   wr_data,
    output logic               busy
);

    logic          s1_vld_reg;
    logic [KW-1:0] s1_k_reg;
    logic          s2_vld_reg;
    logic [KW-1:0] s2_k_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   prod_next;
    logic [31:0]   acc_reg;

    // Low 32 bits of the product are all the wrapping sum needs
    assign prod_next = elem * secret;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg <= issue_k;
        s2_k_reg <= s1_k_reg;
        prod_reg <= prod_next;
        acc_reg  <= acc_value;
    end

    assign wr_en   = s2_vld_reg;
    assign wr_k    = s2_k_reg;
    assign wr_data = acc_reg + prod_reg;
    assign busy    = s1_vld_reg | s2_vld_reg;

endmodule

`default_nettype wire

// ----- sv/lwe_matrix_times_secret_plus_noise_unit.sv -----
// Top level of the LWE matrix-times-secret-plus-noise unit.
// Computes A*S + E modulo 2^32 one row at a time. A matrix element whose column index is
// below ROWS_N is accepted in idle; then each column gets one secret-store read and one
// 32x32 multiply through a read / multiply / write-back pipeline, which then drains. An
// element with row_done then emits COLS_NHAT sums, each an accumulator read and then an
// output register load that waits while the output side stalls. The next request is taken
// as soon as the last sum sits in the output register. The secret store is not cleared after
// reset: load every secret word before any element reads it. Accumulators read as zero
// after reset and after a row.
`default_nettype none

module lwe_matrix_times_secret_plus_noise_unit #(
    parameter int ROWS_N    = lwe_msn_pkg::ROWS_N_DEF,
    parameter int COLS_NHAT = lwe_msn_pkg::COLS_NHAT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire lwe_msn_pkg::req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output lwe_msn_pkg::rsp_t      rsp
);

    localparam int AW = $clog2(ROWS_N * COLS_NHAT);
    localparam int KW = (COLS_NHAT > 1) ? $clog2(COLS_NHAT) : 1;
    localparam logic [KW-1:0] K_LAST   = KW'(COLS_NHAT - 1);
    localparam logic [12:0]   ROWS_LIM = 13'(ROWS_N);
    localparam logic [10:0]   COLS_LIM = 11'(COLS_NHAT);

    lwe_msn_pkg::state_t state_reg;
    lwe_msn_pkg::state_t state_next;

    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;

    logic [31:0]   elem_reg;
    logic [9:0]    row_reg;
    logic          done_reg;
    logic [AW-1:0] base_reg;

    lwe_msn_pkg::rsp_t rsp_reg;
    logic              rsp_valid_reg;
    logic              out_free;

    logic req_acc;
    logic row_ok;
    logic col_ok_nhat;
    logic col_ok_rows;
    logic secret_wr;
    logic noise_wr;
    logic elem_ld;
    logic issue;
    logic emit_rd;
    logic emit_ld;

    logic [AW-1:0] secret_wr_addr;
    logic [AW-1:0] secret_rd_addr;
    logic [31:0]   secret_rd_data;

    lwe_msn_pkg::acc_ctl_t acc_ctl;
    logic [KW-1:0]         acc_wr_addr;
    logic [31:0]           acc_wr_data;
    logic [31:0]           acc_rd_value;

    logic          mac_wr_en;
    logic [KW-1:0] mac_wr_k;
    logic [31:0]   mac_wr_data;
    logic          mac_busy;

    // Request decode
    assign req_acc     = req_valid && !req_stall;
    assign row_ok      = {3'b000, req.row_index} < ROWS_LIM;
    assign col_ok_nhat = {1'b0, req.col_index} < COLS_LIM;
    assign col_ok_rows = {3'b000, req.col_index} < ROWS_LIM;
    assign secret_wr   = req_acc && (req.req_type == lwe_msn_pkg::REQ_SECRET)
                         && row_ok && col_ok_nhat;
    assign noise_wr    = req_acc && (req.req_type == lwe_msn_pkg::REQ_NOISE) && col_ok_nhat;
    assign elem_ld     = req_acc && (req.req_type == lwe_msn_pkg::REQ_ELEM);

    assign secret_wr_addr = AW'(req.row_index) * AW'(COLS_NHAT) + AW'(req.col_index);
    assign secret_rd_addr = base_reg + AW'(k_reg);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwe_msn_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        req_stall  = 1'b1;
        issue      = 1'b0;
        emit_rd    = 1'b0;
        emit_ld    = 1'b0;
        unique case (state_reg)
            lwe_msn_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                k_next    = '0;
                if (elem_ld)
                begin
                    if (col_ok_rows)
                    begin
                        state_next = lwe_msn_pkg::ST_MAC;
                    end
                    else if (req.row_done)
                    begin
                        state_next = lwe_msn_pkg::ST_EMIT_RD;
                    end
                end
            end
            lwe_msn_pkg::ST_MAC:
            begin
                issue = 1'b1;
                if (k_reg == K_LAST)
                begin
                    state_next = lwe_msn_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            lwe_msn_pkg::ST_DRAIN:
            begin
                k_next = '0;
                if (!mac_busy)
                begin
                    state_next = done_reg ? lwe_msn_pkg::ST_EMIT_RD : lwe_msn_pkg::ST_IDLE;
                end
            end
            lwe_msn_pkg::ST_EMIT_RD:
            begin
                emit_rd    = 1'b1;
                state_next = lwe_msn_pkg::ST_EMIT_WR;
            end
            lwe_msn_pkg::ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    emit_ld = 1'b1;
                    if (k_reg == K_LAST)
                    begin
                        state_next = lwe_msn_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = lwe_msn_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = lwe_msn_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the element and its row context for the whole sweep
    always_ff @(posedge clk)
    begin
        if (elem_ld)
        begin
            elem_reg <= req.data_value;
            row_reg  <= req.row_index;
            done_reg <= req.row_done;
            base_reg <= AW'(req.col_index) * AW'(COLS_NHAT);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit_ld)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ld)
        begin
            rsp_reg.sum_out     <= acc_rd_value;
            rsp_reg.out_row     <= row_reg;
            rsp_reg.out_column  <= 4'(k_reg);
            rsp_reg.last_of_row <= (k_reg == K_LAST);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Accumulator port sharing: noise loads only in idle, write-back only during a sweep
    assign acc_ctl.wr  = noise_wr || mac_wr_en;
    assign acc_ctl.rd  = issue || emit_rd;
    assign acc_ctl.clr = emit_ld;
    assign acc_wr_addr = mac_wr_en ? mac_wr_k : KW'(req.col_index);
    assign acc_wr_data = mac_wr_en ? mac_wr_data : req.data_value;

    lwe_msn_secret_mem #(
        .ROWS_N    (ROWS_N),
        .COLS_NHAT (COLS_NHAT)
    ) u_secret_mem (
        .clk     (clk),
        .wr_en   (secret_wr),
        .wr_addr (secret_wr_addr),
        .wr_data (req.data_value),
        .rd_en   (issue),
        .rd_addr (secret_rd_addr),
        .rd_data (secret_rd_data)
    );

    lwe_msn_acc_mem #(
        .COLS_NHAT (COLS_NHAT)
    ) u_acc_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (acc_ctl),
        .wr_addr  (acc_wr_addr),
        .wr_data  (acc_wr_data),
        .rd_addr  (k_reg),
        .rd_value (acc_rd_value)
    );

    lwe_msn_mac #(
        .COLS_NHAT (COLS_NHAT)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_k   (k_reg),
        .elem      (elem_reg),
        .secret    (secret_rd_data),
        .acc_value (acc_rd_value),
        .wr_en     (mac_wr_en),
        .wr_k      (mac_wr_k),
        .wr_data   (mac_wr_data),
        .busy      (mac_busy)
    );

    a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        mac_wr_en |-> (state_reg == lwe_msn_pkg::ST_MAC || state_reg == lwe_msn_pkg::ST_DRAIN))
        else $error("accumulator write-back outside a sweep");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lwe_msn_pkg::ST_EMIT_RD || state_reg == lwe_msn_pkg::ST_IDLE) |-> !mac_busy)
        else $error("pipeline still busy when emitting or idle");

    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last_of_row) |-> (rsp.out_column == 4'(COLS_NHAT - 1)))
        else $error("last sum of row carries wrong column");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(noise_wr && mac_wr_en))
        else $error("noise load collides with accumulator write-back");

endmodule

`default_nettype wire

// ----- test/lwe_matrix_times_secret_plus_noise_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LWE matrix-times-secret-plus-noise unit.
module lwe_matrix_times_secret_plus_noise_unit_test;

    localparam int ROWS         = lwe_msn_pkg::ROWS_N_DEF;
    localparam int NHAT         = lwe_msn_pkg::COLS_NHAT_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    lwe_msn_pkg::req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    lwe_msn_pkg::rsp_t rsp;

    lwe_matrix_times_secret_plus_noise_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lwe_msn_pkg::req_t pending_reqs[$];
    lwe_msn_pkg::rsp_t expected_sums[$];

    // Product model state
    logic [31:0] secret_words [ROWS*NHAT];
    logic [31:0] row_sums [NHAT] = '{default: '0};

    // Generator bookkeeping: which secret rows are fully written
    bit [NHAT-1:0] written_mask [ROWS];
    bit            row_ready [ROWS];
    int            ready_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int queued_count   = 0;
    int taken_count    = 0;
    int useful_count   = 0;
    int cycle_count    = 0;
    int loads_seen     = 0;
    int elements_seen  = 0;
    int rows_seen      = 0;
    int sums_checked   = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    task automatic update_product_model(input lwe_msn_pkg::req_t r);
        int k;
        case (r.req_type)
            lwe_msn_pkg::REQ_SECRET:
            begin
                loads_seen++;
                if (r.col_index < NHAT)
                    secret_words[int'(r.row_index) * NHAT + int'(r.col_index)] = r.data_value;
            end
            lwe_msn_pkg::REQ_NOISE:
            begin
                loads_seen++;
                if (r.col_index < NHAT)
                    row_sums[r.col_index] = r.data_value;
            end
            lwe_msn_pkg::REQ_ELEM:
            begin
                elements_seen++;
                if (r.col_index < ROWS)
                    for (k = 0; k < NHAT; k++)
                        row_sums[k] = row_sums[k]
                                    + r.data_value * secret_words[int'(r.col_index) * NHAT + k];
                if (r.row_done)
                begin
                    rows_seen++;
                    for (k = 0; k < NHAT; k++)
                    begin
                        expected_sums.push_back(lwe_msn_pkg::rsp_t'{sum_out: row_sums[k],
                                                       out_row: r.row_index,
                                                       out_column: 4'(k),
                                                       last_of_row: (k == NHAT - 1)});
                        row_sums[k] = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_sum(input lwe_msn_pkg::rsp_t got);
        lwe_msn_pkg::rsp_t want;
        if (expected_sums.size() == 0)
        begin
            report_mismatch($sformatf("unexpected sum %h row %0d column %0d",
                                      got.sum_out, got.out_row, got.out_column));
            return;
        end
        want = expected_sums.pop_front();
        sums_checked++;
        if (got.sum_out !== want.sum_out)
            report_mismatch($sformatf("row %0d column %0d: sum %h, want %h",
                                      want.out_row, want.out_column, got.sum_out, want.sum_out));
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("column %0d: row %0d, want %0d",
                                      want.out_column, got.out_row, want.out_row));
        if (got.out_column !== want.out_column)
            report_mismatch($sformatf("row %0d: column %0d, want %0d",
                                      want.out_row, got.out_column, want.out_column));
        if (got.last_of_row !== want.last_of_row)
            report_mismatch($sformatf("row %0d column %0d: last flag %b, want %b",
                                      want.out_row, want.out_column,
                                      got.last_of_row, want.last_of_row));
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                update_product_model(req);
                taken_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_sum(rsp);
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    function automatic lwe_msn_pkg::req_t make_req(input logic [1:0] kind, input int row,
                                                   input int col, input logic [31:0] word,
                                                   input logic done);
        lwe_msn_pkg::req_t r;
        r.req_type   = kind;
        r.row_index  = 10'(row);
        r.col_index  = 10'(col);
        r.data_value = word;
        r.row_done   = done;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input lwe_msn_pkg::req_t r);
        int j;
        j = int'(r.row_index);
        if (r.req_type == lwe_msn_pkg::REQ_SECRET && r.col_index < NHAT)
        begin
            written_mask[j][r.col_index] = 1'b1;
            if (&written_mask[j] && !row_ready[j])
            begin
                row_ready[j] = 1'b1;
                ready_rows.push_back(j);
            end
        end
        if (r.req_type == lwe_msn_pkg::REQ_ELEM
            || (r.req_type != REQ_UNUSED && r.col_index < NHAT))
            useful_count++;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    task automatic load_secret_row(input int row);
        int k;
        for (k = 0; k < NHAT; k++)
            queue_item(make_req(lwe_msn_pkg::REQ_SECRET, row, k, pick_word(),
                                1'($urandom_range(1))));
    endtask

    // Noise for some columns, then a few elements; the last one closes the row
    task automatic queue_row_sequence();
        int out_row;
        int n_elem;
        int e;
        out_row = $urandom_range(ROWS - 1);
        repeat ($urandom_range(NHAT))
            queue_item(make_req(lwe_msn_pkg::REQ_NOISE, $urandom_range(ROWS - 1),
                                $urandom_range(NHAT - 1), pick_word(), 1'($urandom_range(1))));
        n_elem = $urandom_range(1, 4);
        for (e = 0; e < n_elem; e++)
            queue_item(make_req(lwe_msn_pkg::REQ_ELEM, out_row,
                                ready_rows[$urandom_range(ready_rows.size() - 1)],
                                pick_word(), e == n_elem - 1));
    endtask

    task automatic queue_side_item();
        case ($urandom_range(4))
            0: queue_item(make_req(REQ_UNUSED, $urandom_range(ROWS - 1), $urandom_range(ROWS - 1),
                                   $urandom, 1'($urandom_range(1))));
            1: queue_item(make_req(lwe_msn_pkg::REQ_SECRET, $urandom_range(ROWS - 1),
                                   $urandom_range(NHAT, ROWS - 1), $urandom,
                                   1'($urandom_range(1))));
            2: queue_item(make_req(lwe_msn_pkg::REQ_NOISE, $urandom_range(ROWS - 1),
                                   $urandom_range(NHAT, ROWS - 1), $urandom,
                                   1'($urandom_range(1))));
            3: queue_item(make_req(lwe_msn_pkg::REQ_SECRET, $urandom_range(ROWS - 1),
                                   $urandom_range(NHAT - 1), pick_word(),
                                   1'($urandom_range(1))));
            default: load_secret_row($urandom_range(ROWS - 1));
        endcase
    endtask

    task automatic queue_random_phase(input int target);
        int start;
        start = useful_count;
        while (useful_count - start < target)
        begin
            if ($urandom_range(99) < 75)
                queue_row_sequence();
            else
                queue_side_item();
        end
    endtask

    task automatic queue_directed();
        int k;
        for (k = 0; k < NHAT; k++)
        begin
            queue_item(make_req(lwe_msn_pkg::REQ_SECRET, 0, k, '1, 1'b0));
            queue_item(make_req(lwe_msn_pkg::REQ_SECRET, ROWS - 1, k,
                                (k % 2) ? $urandom : 32'h8000_0001, 1'b1));
        end
        queue_item(make_req(REQ_UNUSED, ROWS - 1, ROWS - 1, '1, 1'b1));
        queue_item(make_req(lwe_msn_pkg::REQ_SECRET, ROWS - 1, ROWS - 1, '1, 1'b1));
        queue_item(make_req(lwe_msn_pkg::REQ_NOISE, ROWS - 1, ROWS - 1, '1, 1'b0));
        queue_item(make_req(lwe_msn_pkg::REQ_NOISE, 0, 0, '1, 1'b0));
        queue_item(make_req(lwe_msn_pkg::REQ_NOISE, ROWS - 1, NHAT - 1, '1, 1'b1));
        queue_item(make_req(lwe_msn_pkg::REQ_ELEM, ROWS - 1, 0, '1, 1'b0));
        queue_item(make_req(lwe_msn_pkg::REQ_ELEM, ROWS - 1, ROWS - 1, '1, 1'b1));
        // accumulators are clear again: a zero element must give zero sums
        queue_item(make_req(lwe_msn_pkg::REQ_ELEM, 0, 0, '0, 1'b1));
        queue_item(make_req(lwe_msn_pkg::REQ_ELEM, 512, ROWS - 1, 32'd1, 1'b1));
    endtask

    task automatic wait_for_drain();
        while (taken_count != queued_count)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 26;
        recv_stall_pct = 68;
        queue_directed();
        queue_random_phase(50);
        wait_for_drain();

        send_idle_pct  = 68;
        recv_stall_pct = 26;
        queue_random_phase(50);
        wait_for_drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_phase(50);
        wait_for_drain();

        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d secret and noise loads, %0d matrix elements, %0d rows",
                 loads_seen, elements_seen, rows_seen);
        $display("%0d sums checked over %0d secret rows, %0d mismatches",
                 sums_checked, ready_rows.size(), mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
